// ===== sv/fdtm_pkg.sv =====
package fdtm_pkg;

  // Configuration register indexes.
  localparam logic [2:0] CFG_MAX_DELTA  = 3'd0;
  localparam logic [2:0] CFG_FIXED      = 3'd1;
  localparam logic [2:0] CFG_SMOOTH_EN  = 3'd2;
  localparam logic [2:0] CFG_SMOOTH_N   = 3'd3;
  localparam logic [2:0] CFG_MAX_STEPS  = 3'd4;
  localparam logic [2:0] CFG_TIME_SCALE = 3'd5;

  // Operation codes carried on the request tuser.
  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_POLL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Register reset values.
  localparam logic [23:0] MAX_DELTA_RST  = 24'd250000;
  localparam logic [23:0] FIXED_RST      = 24'd16667;
  localparam logic [5:0]  SMOOTH_N_RST   = 6'd10;
  localparam logic [7:0]  MAX_STEPS_RST  = 8'd5;
  localparam logic [15:0] TIME_SCALE_RST = 16'd256;

  // Frame rate window.
  localparam logic [24:0] FPS_PERIOD_US = 25'd500000;
  localparam logic [23:0] FPS_SCALE     = 24'd16000000;
  localparam logic [19:0] FRAMES_MAX    = 20'hFFFFF;

  // Smallest sample count that is trimmed.
  localparam int TRIM_MIN_N = 5;

  // Shared divider widths.
  localparam int DNW = 48;
  localparam int DDW = 32;

  typedef enum logic [13:0] {
    ST_IDLE     = 14'b00000000000001,
    ST_EXEC     = 14'b00000000000010,
    ST_PREP     = 14'b00000000000100,
    ST_RANK     = 14'b00000000001000,
    ST_KEEP     = 14'b00000000010000,
    ST_SUM      = 14'b00000000100000,
    ST_SM_GO    = 14'b00000001000000,
    ST_SM_WAIT  = 14'b00000010000000,
    ST_FPS_GO   = 14'b00000100000000,
    ST_FPS_WAIT = 14'b00001000000000,
    ST_AL_GO    = 14'b00010000000000,
    ST_AL_WAIT  = 14'b00100000000000,
    ST_SCALE    = 14'b01000000000000,
    ST_DONE     = 14'b10000000000000
  } fdtm_state_e;

  typedef enum logic [2:0] {
    CC_HOLD,
    CC_SHIFT,
    CC_LOAD,
    CC_RANK,
    CC_KEEP,
    CC_ROT
  } fdtm_cmd_e;

  typedef struct packed {
    fdtm_cmd_e cmd;
    logic      first;
  } fdtm_cell_ctrl_t;

endpackage

// ===== sv/fdtm_cell.sv =====
module fdtm_cell import fdtm_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 24,
  parameter int NCW = 6,
  parameter int RW  = 5
) (
  input  logic            clk_i,
  input  fdtm_cell_ctrl_t ctrl_i,
  input  logic [CW-1:0]   smp_i,
  input  logic [CW-1:0]   tok_i,
  input  logic            tokv_i,
  input  logic            tokw_i,
  input  logic [NCW-1:0]  n_i,
  input  logic [NCW-1:0]  trim_i,
  output logic [CW-1:0]   smp_o,
  output logic [CW-1:0]   tok_o,
  output logic            tokv_o,
  output logic            tokw_o
);

  logic [CW-1:0] smp_q, tok_q;
  logic          tokv_q, tokw_q;
  logic [RW-1:0] rank_q;
  logic          in_use, kept, below;

  // A passing sample ranks below ours if smaller, or equal and newer in the chain.
  assign in_use = NCW'(IDX) < n_i;
  assign below  = tokv_q && (tok_q < smp_q || (tok_q == smp_q && !tokw_q));
  assign kept   = in_use && (NCW'(rank_q) >= trim_i) && (NCW'(rank_q) < n_i - trim_i);

  always_ff @(posedge clk_i) begin
    case (ctrl_i.cmd)
      CC_SHIFT: smp_q <= smp_i;
      CC_LOAD: begin
        tok_q  <= smp_q;
        tokv_q <= in_use;
        tokw_q <= 1'b0;
        rank_q <= '0;
      end
      CC_RANK: begin
        if (!ctrl_i.first && below) begin
          rank_q <= rank_q + RW'(1);
        end
        tok_q  <= tok_i;
        tokv_q <= tokv_i;
        tokw_q <= tokw_i;
      end
      CC_KEEP: tok_q <= kept ? smp_q : '0;
      CC_ROT:  tok_q <= tok_i;
      default: ;
    endcase
  end

  assign smp_o  = smp_q;
  assign tok_o  = tok_q;
  assign tokv_o = tokv_q;
  assign tokw_o = tokw_q;

endmodule

// ===== sv/fdtm_div.sv =====
module fdtm_div import fdtm_pkg::*; #(
  parameter int NW = 48,
  parameter int DW = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quo_o
);

  localparam int CNTW = $clog2(NW);

  logic            busy_q, done_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   quo_q;
  logic [DW-1:0]   rem_q, den_q;
  logic [DW:0]     trial;
  logic            fits;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_q, quo_q[NW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// ===== sv/frame_delta_trimmed_mean_timer_core.sv =====
// Frame delta timer with a trimmed-mean smoother and a fixed-step accumulator.
// Requests arrive on the s_axis channel: tuser selects the operation (frame
// begin, fixed-step poll, clear of the timing buffers) and tdata carries the
// elapsed frame time. Every request yields exactly one result on m_axis that
// reports the timer state after the operation.
// Requests are handled one at a time. A frame request shifts its sample into
// the sample chain, which ranks the samples in use and sums the kept ones;
// the shared serial divider then computes the mean and the blend alpha. A
// frame that closes a half-second frame rate window adds a division for the
// frame rate, and a frame with smoothing off or no samples in use skips the
// ranking and the mean. Any other request needs only the alpha division, and
// none is needed with a zero fixed step. Once the result has been registered
// the block returns to idle and can take the next request.
// The result sits in an output register, so the next request may be taken
// while the receiver stalls; a finished result then waits for that register.
// Reset restores the register defaults, empties the sample window and the
// accumulator and sets both last deltas to the default fixed step.
// Configuration is to be written through cfg_we_i only while the block is
// idle; the block itself does not enforce this.
module frame_delta_trimmed_mean_timer_core import fdtm_pkg::*; #(
  parameter int WINDOW_DEPTH = 32,
  parameter int TIME_WIDTH   = 24
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [23:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,   // elapsed_us
  input  logic [1:0]   s_axis_tuser,   // operation
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // raw_delta_us, smoothed_delta_us, scaled_delta_us, fps_q4, frames_seen,
  // step_granted, blend_alpha_q8, then seven zero bits
  output logic [167:0] m_axis_tdata
);

  localparam int W    = WINDOW_DEPTH;
  localparam int CW   = (TIME_WIDTH < 24) ? TIME_WIDTH : 24;
  localparam int NCW  = $clog2(W + 1);
  localparam int RW   = $clog2(W);
  localparam int LW   = (NCW > 6) ? NCW : 6;
  localparam int SUMW = CW + $clog2(W);
  localparam logic [23:0] TMASK = 24'((64'd1 << CW) - 64'd1);

  // Configuration registers.
  logic [23:0] max_delta_q, fixed_q;
  logic        smen_q;
  logic [5:0]  sf_q;
  logic [7:0]  mfu_q;
  logic [15:0] scale_q;

  fdtm_state_e state_q, state_d;

  logic [1:0]     op_q;
  logic [23:0]    elapsed_q;
  logic [23:0]    last_raw_q, last_sm_q, scaled_q, fps_est_q;
  logic [15:0]    alpha_q;
  logic           granted_q;
  logic [47:0]    frames_total_q;
  logic [24:0]    fps_us_q;
  logic [19:0]    fps_fr_q;
  logic           fps_close_q;
  logic [43:0]    fps_num_q;
  logic [31:0]    acc_q;
  logic [7:0]     steps_q;
  logic [NCW-1:0] filled_q;
  logic [RW-1:0]  cnt_q;
  logic [SUMW-1:0] sum_q;
  logic           m_valid_q;
  logic [167:0]   m_data_q;

  logic [23:0]    raw_masked, raw_w;
  logic [32:0]    acc_sum;
  logic [24:0]    fps_us_sum;
  logic [LW-1:0]  n_lw;
  logic [NCW-1:0] n_w, trim_w, m_w;
  logic           skip_sm, out_free, rank_last;
  logic [39:0]    scale_prod;
  logic [31:0]    scale_shr;

  fdtm_cell_ctrl_t cell_ctrl;
  logic            div_start, div_done;
  logic [DNW-1:0]  div_num, div_quo;
  logic [DDW-1:0]  div_den;

  logic [CW-1:0] smp [W];
  logic [CW-1:0] tok [W];
  logic          tokv [W];
  logic          tokw [W];

  assign raw_masked = elapsed_q & TMASK;
  assign raw_w      = (raw_masked > max_delta_q) ? max_delta_q : raw_masked;
  assign acc_sum    = {1'b0, acc_q} + 33'(raw_w);
  assign fps_us_sum = fps_us_q + 25'(raw_w);

  // Samples in use: the fill level, capped by the configured smoothing length.
  assign n_lw    = (LW'(filled_q) < LW'(sf_q)) ? LW'(filled_q) : LW'(sf_q);
  assign n_w     = NCW'(n_lw);
  assign trim_w  = (n_w >= NCW'(TRIM_MIN_N)) ? (n_w >> 2) : '0;
  assign m_w     = n_w - (trim_w << 1);
  assign skip_sm = !smen_q || (n_w == '0);

  assign rank_last  = cnt_q == RW'(W - 1);
  assign out_free   = !m_valid_q || m_axis_tready;
  assign scale_prod = last_sm_q * scale_q;
  assign scale_shr  = scale_prod[39:8];

  // The sample chain: the newest sample enters cell 0, tokens circulate in a ring.
  for (genvar k = 0; k < W; k++) begin : g_cell
    fdtm_cell #(
      .IDX(k),
      .CW (CW),
      .NCW(NCW),
      .RW (RW)
    ) u_cell (
      .clk_i (clk_i),
      .ctrl_i(cell_ctrl),
      .smp_i ((k == 0) ? CW'(raw_w) : smp[(k == 0) ? 0 : k - 1]),
      .tok_i (tok[(k == 0) ? W - 1 : k - 1]),
      .tokv_i(tokv[(k == 0) ? W - 1 : k - 1]),
      .tokw_i((k == 0) ? 1'b1 : tokw[(k == 0) ? 0 : k - 1]),
      .n_i   (n_w),
      .trim_i(trim_w),
      .smp_o (smp[k]),
      .tok_o (tok[k]),
      .tokv_o(tokv[k]),
      .tokw_o(tokw[k])
    );
  end

  fdtm_div #(
    .NW(DNW),
    .DW(DDW)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // Cell commands and divider operands follow the sequencer state.
  always_comb begin
    cell_ctrl.cmd   = CC_HOLD;
    cell_ctrl.first = cnt_q == '0;
    div_start       = 1'b0;
    div_num         = 48'(sum_q);
    div_den         = 32'(m_w);
    unique case (state_q)
      ST_EXEC: if (op_q == OP_FRAME) cell_ctrl.cmd = CC_SHIFT;
      ST_PREP: if (!skip_sm) cell_ctrl.cmd = CC_LOAD;
      ST_RANK: cell_ctrl.cmd = CC_RANK;
      ST_KEEP: cell_ctrl.cmd = CC_KEEP;
      ST_SUM:  cell_ctrl.cmd = CC_ROT;
      ST_SM_GO: div_start = 1'b1;
      ST_FPS_GO: begin
        div_start = fps_close_q;
        div_num   = 48'(fps_num_q);
        div_den   = 32'(fps_us_q);
      end
      ST_AL_GO: begin
        div_start = fixed_q != '0;
        div_num   = {8'd0, acc_q, 8'd0};
        div_den   = 32'(fixed_q);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (s_axis_tvalid) state_d = ST_EXEC;
      ST_EXEC:     state_d = (op_q == OP_FRAME) ? ST_PREP : ST_AL_GO;
      ST_PREP:     state_d = skip_sm ? ST_FPS_GO : ST_RANK;
      ST_RANK:     if (rank_last) state_d = ST_KEEP;
      ST_KEEP:     state_d = ST_SUM;
      ST_SUM:      if (rank_last) state_d = ST_SM_GO;
      ST_SM_GO:    state_d = ST_SM_WAIT;
      ST_SM_WAIT:  if (div_done) state_d = ST_FPS_GO;
      ST_FPS_GO:   state_d = fps_close_q ? ST_FPS_WAIT : ST_AL_GO;
      ST_FPS_WAIT: if (div_done) state_d = ST_AL_GO;
      ST_AL_GO:    state_d = (fixed_q == '0) ? ST_SCALE : ST_AL_WAIT;
      ST_AL_WAIT:  if (div_done) state_d = ST_SCALE;
      ST_SCALE:    state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      max_delta_q    <= MAX_DELTA_RST;
      fixed_q        <= FIXED_RST;
      smen_q         <= 1'b1;
      sf_q           <= SMOOTH_N_RST;
      mfu_q          <= MAX_STEPS_RST;
      scale_q        <= TIME_SCALE_RST;
      last_raw_q     <= FIXED_RST;
      last_sm_q      <= FIXED_RST;
      fps_est_q      <= '0;
      frames_total_q <= '0;
      fps_us_q       <= '0;
      fps_fr_q       <= '0;
      fps_close_q    <= 1'b0;
      acc_q          <= '0;
      steps_q        <= '0;
      filled_q       <= '0;
      granted_q      <= 1'b0;
      cnt_q          <= '0;
      m_valid_q      <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_MAX_DELTA:  max_delta_q <= cfg_wdata_i;
          CFG_FIXED:      fixed_q     <= cfg_wdata_i;
          CFG_SMOOTH_EN:  smen_q      <= cfg_wdata_i[0];
          CFG_SMOOTH_N:   sf_q        <= cfg_wdata_i[5:0];
          CFG_MAX_STEPS:  mfu_q       <= cfg_wdata_i[7:0];
          CFG_TIME_SCALE: scale_q     <= cfg_wdata_i[15:0];
          default: ;
        endcase
      end

      unique case (state_q)
        ST_EXEC: begin
          granted_q <= 1'b0;
          unique case (op_q)
            OP_FRAME: begin
              last_raw_q     <= raw_w;
              filled_q       <= (filled_q == NCW'(W)) ? filled_q : filled_q + NCW'(1);
              acc_q          <= acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
              steps_q        <= '0;
              frames_total_q <= frames_total_q + 48'd1;
              fps_us_q       <= fps_us_sum;
              fps_fr_q       <= (fps_fr_q == FRAMES_MAX) ? fps_fr_q : fps_fr_q + 20'd1;
              fps_close_q    <= fps_us_sum >= FPS_PERIOD_US;
            end
            OP_POLL: begin
              if (steps_q >= mfu_q) begin
                // Per-frame cap reached: the leftover time is dropped.
                acc_q <= '0;
              end else if (acc_q >= 32'(fixed_q)) begin
                acc_q     <= acc_q - 32'(fixed_q);
                steps_q   <= steps_q + 8'd1;
                granted_q <= 1'b1;
              end
            end
            OP_CLEAR: begin
              filled_q <= '0;
              acc_q    <= '0;
              steps_q  <= '0;
            end
            default: ;
          endcase
        end
        ST_PREP: begin
          cnt_q <= '0;
          if (skip_sm) begin
            last_sm_q <= last_raw_q;
          end
        end
        ST_RANK: cnt_q <= rank_last ? '0 : cnt_q + RW'(1);
        ST_SUM:  cnt_q <= rank_last ? '0 : cnt_q + RW'(1);
        ST_SM_WAIT: if (div_done) last_sm_q <= 24'(div_quo);
        ST_FPS_WAIT: begin
          if (div_done) begin
            fps_est_q <= (div_quo > 48'hFF_FFFF) ? 24'hFF_FFFF : div_quo[23:0];
            fps_us_q  <= '0;
            fps_fr_q  <= '0;
          end
        end
        default: ;
      endcase

      if (state_q == ST_DONE && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && s_axis_tvalid) begin
      op_q      <= s_axis_tuser;
      elapsed_q <= s_axis_tdata;
    end
    if (state_q == ST_PREP) begin
      fps_num_q <= fps_fr_q * FPS_SCALE;
    end
    if (state_q == ST_KEEP) begin
      sum_q <= '0;
    end else if (state_q == ST_SUM) begin
      sum_q <= sum_q + SUMW'(tok[W - 1]);
    end
    if (state_q == ST_AL_GO && fixed_q == '0) begin
      alpha_q <= (acc_q != '0) ? 16'hFFFF : 16'h0000;
    end else if (state_q == ST_AL_WAIT && div_done) begin
      alpha_q <= (div_quo > 48'hFFFF) ? 16'hFFFF : div_quo[15:0];
    end
    if (state_q == ST_SCALE) begin
      scaled_q <= (scale_shr > 32'hFF_FFFF) ? 24'hFF_FFFF : scale_shr[23:0];
    end
    if (state_q == ST_DONE && out_free) begin
      m_data_q <= {7'd0, alpha_q, granted_q, frames_total_q, fps_est_q,
                   scaled_q, last_sm_q, last_raw_q};
    end
  end

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

endmodule

// ===== tb/frame_delta_trimmed_mean_timer_core_test.sv =====
`timescale 1ns / 1ps

module frame_delta_trimmed_mean_timer_core_test;
  import fdtm_pkg::*;

  // One request as it travels on the slave side.
  typedef struct packed {
    logic [1:0]  op;
    logic [23:0] elapsed;
  } timer_req_t;

  // One result, unpacked into its fields.
  typedef struct packed {
    logic [23:0] raw;
    logic [23:0] smoothed;
    logic [23:0] scaled;
    logic [23:0] fps;
    logic [47:0] frames;
    logic        granted;
    logic [15:0] alpha;
  } timer_res_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 300;

  // The operation code that the block leaves unused.
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [23:0]  cfg_wdata_i;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [23:0]  s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b1;
  logic [167:0] m_axis_tdata;
  logic         req_taken;

  frame_delta_trimmed_mean_timer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predictor state: a private copy of the registers and the timer state.
  logic [23:0] p_max_delta, p_fixed;
  logic        p_smooth_en;
  logic [5:0]  p_smooth_n;
  logic [7:0]  p_max_steps;
  logic [15:0] p_scale;
  logic [23:0] p_ring [32];
  int unsigned p_slot = 0, p_count = 0;
  logic [31:0] p_acc = '0;
  logic [7:0]  p_steps = '0;
  logic [47:0] p_frames = '0;
  logic [24:0] p_win_us = '0;
  logic [19:0] p_win_frames = '0;
  logic [23:0] p_fps = '0;
  logic [23:0] p_last_raw = FIXED_RST, p_last_smoothed = FIXED_RST;

  timer_req_t pending_reqs[$];
  timer_res_t expected_results[$];

  int  idle_pct, stall_pct;
  int  quiet_cycles = 0;
  bit  failed = 1'b0;

  // Trimmed mean over the most recent samples of the ring.
  function automatic logic [23:0] trimmed_mean(input logic [23:0] raw);
    logic [23:0] pick [32];
    logic [23:0] v;
    logic [63:0] sum;
    int n, i, j, trim;
    if (!p_smooth_en || p_count == 0) return raw;
    n = p_count;
    if (p_smooth_n < n) n = p_smooth_n;
    if (n == 0) return raw;
    for (i = 0; i < n; i++) begin
      v = p_ring[(p_slot + 31 - i) % 32];
      j = i;
      while (j > 0 && pick[j - 1] > v) begin
        pick[j] = pick[j - 1];
        j--;
      end
      pick[j] = v;
    end
    trim = (n >= 5) ? n / 4 : 0;
    sum = 0;
    for (i = trim; i < n - trim; i++) sum += pick[i];
    return 24'(sum / 64'(n - 2 * trim));
  endfunction

  task automatic predict_timer(input timer_req_t req);
    timer_res_t r;
    logic [23:0] raw;
    logic [63:0] wide;
    r = '0;
    if (req.op == OP_FRAME) begin
      raw = (req.elapsed > p_max_delta) ? p_max_delta : req.elapsed;
      p_last_raw = raw;
      p_ring[p_slot] = raw;
      p_slot = (p_slot + 1) % 32;
      if (p_count < 32) p_count++;
      p_last_smoothed = trimmed_mean(raw);
      wide = 64'(p_acc) + 64'(raw);
      p_acc = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
      p_steps = '0;
      p_frames = p_frames + 48'd1;
      p_win_us = p_win_us + 25'(raw);
      if (p_win_frames < FRAMES_MAX) p_win_frames++;
      if (p_win_us >= FPS_PERIOD_US) begin
        wide = 64'(p_win_frames) * 64'd16000000 / 64'(p_win_us);
        p_fps = (wide > 64'hFF_FFFF) ? 24'hFF_FFFF : wide[23:0];
        p_win_us = '0;
        p_win_frames = '0;
      end
    end else if (req.op == OP_POLL) begin
      if (p_steps >= p_max_steps) begin
        p_acc = '0;
      end else if (p_acc >= 32'(p_fixed)) begin
        p_acc = p_acc - 32'(p_fixed);
        p_steps++;
        r.granted = 1'b1;
      end
    end else if (req.op == OP_CLEAR) begin
      p_slot = 0;
      p_count = 0;
      p_acc = '0;
      p_steps = '0;
    end
    wide = (64'(p_last_smoothed) * 64'(p_scale)) >> 8;
    r.scaled = (wide > 64'hFF_FFFF) ? 24'hFF_FFFF : wide[23:0];
    if (p_fixed == 0) begin
      r.alpha = (p_acc != 0) ? 16'hFFFF : 16'h0;
    end else begin
      wide = (64'(p_acc) << 8) / 64'(p_fixed);
      r.alpha = (wide > 64'hFFFF) ? 16'hFFFF : wide[15:0];
    end
    r.raw = p_last_raw;
    r.smoothed = p_last_smoothed;
    r.fps = p_fps;
    r.frames = p_frames;
    expected_results.push_back(r);
  endtask

  // Driver: offers the oldest pending request, with random idle cycles.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (req_taken) begin
        predict_timer(timer_req_t'{s_axis_tuser, s_axis_tdata});
        void'(pending_reqs.pop_front());
      end
      if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= pending_reqs[0].op;
        s_axis_tdata  <= pending_reqs[0].elapsed;
      end else if (!(s_axis_tvalid && !req_taken)) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= 24'($urandom);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // The handshake is evaluated at the falling edge from values sampled at the
  // rising edge, so the driver sees a stable picture of the accepted request.
  always @(posedge clk_i) req_taken <= s_axis_tvalid && s_axis_tready;

  // Monitor: compares every accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    timer_res_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{m_axis_tdata[23:0], m_axis_tdata[47:24], m_axis_tdata[71:48],
                m_axis_tdata[95:72], m_axis_tdata[143:96], m_axis_tdata[144],
                m_axis_tdata[160:145]};
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %h", $time, m_axis_tdata);
          failed = 1'b1;
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %h actual %h", $time, want, got);
            failed = 1'b1;
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("frame_delta_trimmed_mean_timer_core regression: fail");
      $finish;
    end
  end

  // Register write on the falling edge, mirrored into the predictor.
  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MAX_DELTA:  p_max_delta = val;
      CFG_FIXED:      p_fixed = val;
      CFG_SMOOTH_EN:  p_smooth_en = val[0];
      CFG_SMOOTH_N:   p_smooth_n = val[5:0];
      CFG_MAX_STEPS:  p_max_steps = val[7:0];
      CFG_TIME_SCALE: p_scale = val[15:0];
      default: ;
    endcase
  endtask

  // Waits until every request has been taken and every result has arrived.
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_results.size() > 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_req(input logic [1:0] op, input logic [23:0] el);
    pending_reqs.push_back(timer_req_t'{op, el});
  endtask

  // Random elapsed times: mostly ordinary frame times, sometimes extremes.
  function automatic logic [23:0] rand_elapsed();
    case ($urandom_range(9))
      0:       return 24'($urandom);
      1:       return 24'($urandom_range(0, 3));
      2:       return 24'hFF_FFFF;
      default: return 24'($urandom_range(5000, 60000));
    endcase
  endfunction

  task automatic random_phase(input int n_items);
    int k;
    for (k = 0; k < n_items; k++) begin
      // Frames followed by a burst of polls, as a game loop issues them.
      push_req(OP_FRAME, rand_elapsed());
      repeat ($urandom_range(0, 7)) push_req(OP_POLL, 24'($urandom));
      case ($urandom_range(19))
        0: push_req(OP_CLEAR, 24'($urandom));
        1: push_req(OP_SPARE, 24'($urandom));
        default: ;
      endcase
    end
  endtask

  initial begin
    int ph;
    idle_pct = 0;
    stall_pct = 0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    p_max_delta = MAX_DELTA_RST;
    p_fixed = FIXED_RST;
    p_smooth_en = 1'b1;
    p_smooth_n = SMOOTH_N_RST;
    p_max_steps = MAX_STEPS_RST;
    p_scale = TIME_SCALE_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part with reset settings: a poll before any frame, extremes of
    // the elapsed time, the clamp, the clear, the unused code and a full cap.
    push_req(OP_POLL, 24'h0);
    push_req(OP_FRAME, 24'h0);
    push_req(OP_FRAME, 24'hFF_FFFF);
    push_req(OP_FRAME, 24'd16667);
    push_req(OP_FRAME, 24'd1);
    push_req(OP_FRAME, 24'd33333);
    push_req(OP_FRAME, 24'd200000);
    repeat (7) push_req(OP_POLL, 24'hFF_FFFF);
    push_req(OP_SPARE, 24'hAAAAAA);
    push_req(OP_CLEAR, 24'h555555);
    push_req(OP_POLL, 24'h0);
    push_req(OP_FRAME, 24'd10);
    wait_idle();

    // Extreme settings: zero fixed step, smoothing over the whole window.
    write_reg(CFG_FIXED, 24'd0);
    write_reg(CFG_SMOOTH_N, 24'd32);
    write_reg(CFG_MAX_STEPS, 24'd255);
    write_reg(CFG_TIME_SCALE, 24'hFFFF);
    write_reg(CFG_MAX_DELTA, 24'hFF_FFFF);
    push_req(OP_FRAME, 24'hFF_FFFF);
    push_req(OP_POLL, 24'h0);
    push_req(OP_FRAME, 24'h0);
    repeat (3) push_req(OP_POLL, 24'h0);
    wait_idle();

    // Random phases over several settings and idling mixes.
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 53; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 53; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      case (ph)
        0: begin
          write_reg(CFG_MAX_DELTA, 24'd250000);
          write_reg(CFG_FIXED, 24'd16667);
          write_reg(CFG_SMOOTH_N, 24'd10);
          write_reg(CFG_MAX_STEPS, 24'd5);
          write_reg(CFG_TIME_SCALE, 24'd256);
        end
        1: begin
          write_reg(CFG_SMOOTH_EN, 24'd0);
          write_reg(CFG_FIXED, 24'd1);
          write_reg(CFG_MAX_STEPS, 24'd0);
        end
        2: begin
          write_reg(CFG_SMOOTH_EN, 24'd1);
          write_reg(CFG_SMOOTH_N, 24'd0);
          write_reg(CFG_FIXED, 24'hFF_FFFF);
          write_reg(CFG_MAX_DELTA, 24'd1);
        end
        3: begin
          write_reg(CFG_SMOOTH_N, 24'd63);
          write_reg(CFG_MAX_DELTA, 24'hFF_FFFF);
          write_reg(CFG_FIXED, 24'd8333);
          write_reg(CFG_TIME_SCALE, 24'd0);
          write_reg(CFG_MAX_STEPS, 24'd3);
        end
        default: begin
          write_reg(CFG_SMOOTH_EN, 24'($urandom_range(1)));
          write_reg(CFG_SMOOTH_N, 24'($urandom_range(1, 32)));
          write_reg(CFG_MAX_DELTA, 24'($urandom_range(20000, 300000)));
          write_reg(CFG_FIXED, 24'($urandom_range(1, 40000)));
          write_reg(CFG_MAX_STEPS, 24'($urandom_range(0, 255)));
          write_reg(CFG_TIME_SCALE, 24'($urandom_range(0, 65535)));
        end
      endcase
      random_phase(42);
      wait_idle();
    end

    if (!failed) begin
      $display("frame_delta_trimmed_mean_timer_core regression: pass");
    end else begin
      $display("frame_delta_trimmed_mean_timer_core regression: fail");
    end
    $finish;
  end

endmodule
